// ===== rtl/core/cfe_pkg.sv =====
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types, codes and constants of the cuckoo filter engine.
// ----------------------------------------------------------------------------
package cfe_pkg;

	// Default geometry limits.
	localparam int LOG2_MAX_BUCKETS_DEF = 10;
	localparam int MAX_SLOTS_DEF        = 4;

	// Alternate bucket multiplier and fingerprint modulus.
	localparam logic [31:0] ALT_MUL = 32'h5bd1e995;
	localparam logic [8:0]  FP_MOD  = 9'd255;

	// Width of a multiplier product of a fingerprint and ALT_MUL.
	localparam int PROD_W = 40;

	// Register reset values.
	localparam logic [3:0] LOG2_RST  = 4'd10;
	localparam logic [2:0] SLOTS_RST = 3'd2;
	localparam logic [9:0] KICKS_RST = 10'd20;

	// Register indexes.
	localparam logic [1:0] CFG_LOG2  = 2'd0;
	localparam logic [1:0] CFG_SLOTS = 2'd1;
	localparam logic [1:0] CFG_KICKS = 2'd2;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_EXISTS = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_COUNT  = 2'd3
	} req_t;

	// Effective configuration after saturation.
	typedef struct packed {
		logic [4:0] log2;
		logic [3:0] slots;
		logic [9:0] kicks;
	} cfg_t;

	// Status from the back end to the front end.
	typedef struct packed {
		logic clearing;
	} stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_FP,
		F_MUL,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_RD,
		B_CHK,
		B_KSTART,
		B_KSWAP,
		B_KMUL,
		B_KALT,
		B_KRD,
		B_KCHK,
		B_RBSTART,
		B_RMUL,
		B_RALT,
		B_RRD,
		B_RSWAP,
		B_OUT
	} back_state_t;

endpackage

// ===== rtl/core/cfe_front.sv =====
// ----------------------------------------------------------------------------
// cfe_front
// Accepts requests, forms the fingerprint and both candidate buckets.
// ----------------------------------------------------------------------------
module cfe_front #(
	parameter int LOG2_MAX_BUCKETS = cfe_pkg::LOG2_MAX_BUCKETS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [63:0]                   hash_value,
	input  logic [LOG2_MAX_BUCKETS-1:0]   mask,
	input  cfe_pkg::stat_t                stat,
	output logic                          push_valid,
	input  logic                          push_ready,
	output logic [10+2*LOG2_MAX_BUCKETS-1:0] push_data
);

	localparam int BW = LOG2_MAX_BUCKETS;

	cfe_pkg::front_state_t st_q, nxt;

	logic [1:0]                  req_q;
	logic [63:0]                 hash_q;
	logic [7:0]                  fp_q;
	logic [BW-1:0]               b0_q;
	logic [cfe_pkg::PROD_W-1:0]  prod_q;

	logic [10:0] bsum;
	logic [8:0]  fold;
	logic [7:0]  rem;
	logic [BW-1:0] b1;

	// Hash mod 255: sum of bytes, one fold, one conditional subtract.
	always_comb begin
		bsum = '0;
		for (int i = 0; i < 8; i++) begin
			bsum = bsum + 11'(hash_q[8*i +: 8]);
		end
		fold = 9'(bsum[7:0]) + 9'(bsum[10:8]);
		rem  = (fold >= cfe_pkg::FP_MOD) ? 8'(fold - cfe_pkg::FP_MOD) : fold[7:0];
	end

	assign b1        = (b0_q ^ prod_q[BW-1:0]) & mask;
	assign push_data = {req_q, fp_q, b0_q, b1};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cfe_pkg::F_IDLE;
		end else begin
			st_q <= nxt;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		nxt        = st_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		case (st_q)
			cfe_pkg::F_IDLE: begin
				in_ready = !stat.clearing;
				if (in_valid && !stat.clearing) nxt = cfe_pkg::F_FP;
			end
			cfe_pkg::F_FP:  nxt = cfe_pkg::F_MUL;
			cfe_pkg::F_MUL: nxt = cfe_pkg::F_PUSH;
			cfe_pkg::F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) nxt = cfe_pkg::F_IDLE;
			end
			default: nxt = cfe_pkg::F_IDLE;
		endcase
	end

	// Item datapath.
	always_ff @(posedge clk) begin
		case (st_q)
			cfe_pkg::F_IDLE: begin
				req_q  <= req_type;
				hash_q <= hash_value;
			end
			cfe_pkg::F_FP: begin
				fp_q <= rem + 8'd1;
				b0_q <= hash_q[BW-1:0] & mask;
			end
			cfe_pkg::F_MUL: begin
				prod_q <= cfe_pkg::PROD_W'(fp_q) * cfe_pkg::PROD_W'(cfe_pkg::ALT_MUL);
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/cfe_queue.sv =====
// ----------------------------------------------------------------------------
// cfe_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cfe_queue #(
	parameter int WIDTH = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wptr_q, rptr_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop)  rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) ent_q[wptr_q] <= push_data;
	end

endmodule

// ===== rtl/core/cfe_back.sv =====
// ----------------------------------------------------------------------------
// cfe_back
// Holds the fingerprint table and carries out one request at a time.
// ----------------------------------------------------------------------------
module cfe_back #(
	parameter int LOG2_MAX_BUCKETS = cfe_pkg::LOG2_MAX_BUCKETS_DEF,
	parameter int MAX_SLOTS        = cfe_pkg::MAX_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfe_pkg::cfg_t                    cfg,
	input  logic [LOG2_MAX_BUCKETS-1:0]      mask,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  logic [10+2*LOG2_MAX_BUCKETS-1:0] q_data,
	output cfe_pkg::stat_t                   stat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             ok,
	output logic [3:0]                       match_count,
	output logic [12:0]                      items_stored,
	output logic [31:0]                      deletes_done
);

	localparam int BW         = LOG2_MAX_BUCKETS;
	localparam int TABLE_SIZE = (2 ** BW) * MAX_SLOTS;
	localparam int AW         = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int SW         = $clog2(MAX_SLOTS + 1);
	localparam int SIW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW         = BW + SW;

	// Table address of a slot in a bucket.
	function automatic logic [AW-1:0] cell_addr(input logic [BW-1:0] bkt,
			input logic [SIW-1:0] sl, input logic [SW-1:0] n);
		logic [CW-1:0] a;
		a = CW'(bkt) * CW'(n) + CW'(sl);
		return a[AW-1:0];
	endfunction

	cfe_pkg::back_state_t st_q, nxt;

	logic [7:0] mem [TABLE_SIZE];
	logic [7:0] rdata_q;

	cfe_pkg::req_t               req_q;
	logic [7:0]                  fp_q;
	logic [BW-1:0]               b0_q, b1_q, idx_q;
	logic                        k_q;
	logic [SIW-1:0]              s_q, victim_q;
	logic [7:0]                  carry_q;
	logic [cfe_pkg::PROD_W-1:0]  prod_q;
	logic [9:0]                  kick_q;
	logic [3:0]                  cnt_q;
	logic                        okr_q;
	logic [12:0]                 item_q;
	logic [31:0]                 del_q;
	logic [AW-1:0]               clr_q;
	logic                        out_valid_q;
	logic                        ok_o_q;
	logic [3:0]                  cnt_o_q;
	logic [12:0]                 items_o_q;
	logic [31:0]                 del_o_q;

	logic [SW-1:0]  slots;
	logic [BW-1:0]  cur_b;
	logic           last_slot, scan_end, hit_empty, hit_fp;
	logic           mem_we;
	logic [AW-1:0]  waddr, raddr;
	logic [7:0]     wdata;
	logic           inc_item, dec_item, inc_del, out_load;
	logic [SIW-1:0] victim_up, victim_dn;

	assign slots     = cfg.slots[SW-1:0];
	assign cur_b     = k_q ? b1_q : b0_q;
	assign last_slot = (SW'(s_q) == slots - SW'(1));
	assign scan_end  = last_slot && k_q;
	assign hit_empty = (rdata_q == 8'd0);
	assign hit_fp    = (rdata_q == fp_q);
	assign victim_up = (SW'(victim_q) + SW'(1) == slots) ? '0 : victim_q + SIW'(1);
	assign victim_dn = (victim_q == '0) ? SIW'(slots - SW'(1)) : victim_q - SIW'(1);

	assign stat.clearing = (st_q == cfe_pkg::B_CLEAR);
	assign out_valid     = out_valid_q;
	assign ok            = ok_o_q;
	assign match_count   = cnt_o_q;
	assign items_stored  = items_o_q;
	assign deletes_done  = del_o_q;

	// Fingerprint table with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// Next state, table access and counter strobes.
	always_comb begin
		nxt      = st_q;
		mem_we   = 1'b0;
		waddr    = cell_addr(cur_b, s_q, slots);
		raddr    = cell_addr(cur_b, s_q, slots);
		wdata    = 8'd0;
		inc_item = 1'b0;
		dec_item = 1'b0;
		inc_del  = 1'b0;
		out_load = 1'b0;
		q_ready  = 1'b0;
		case (st_q)
			cfe_pkg::B_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				if (clr_q == AW'(TABLE_SIZE - 1)) nxt = cfe_pkg::B_IDLE;
			end
			cfe_pkg::B_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) nxt = cfe_pkg::B_RD;
			end
			cfe_pkg::B_RD: nxt = cfe_pkg::B_CHK;
			cfe_pkg::B_CHK: begin
				case (req_q)
					cfe_pkg::REQ_INSERT: begin
						if (hit_empty) begin
							mem_we   = 1'b1;
							wdata    = fp_q;
							inc_item = 1'b1;
							nxt      = cfe_pkg::B_OUT;
						end else begin
							nxt = scan_end ? cfe_pkg::B_KSTART : cfe_pkg::B_RD;
						end
					end
					cfe_pkg::REQ_DELETE: begin
						if (hit_fp) begin
							mem_we   = 1'b1;
							dec_item = 1'b1;
							inc_del  = 1'b1;
							nxt      = cfe_pkg::B_OUT;
						end else begin
							nxt = scan_end ? cfe_pkg::B_OUT : cfe_pkg::B_RD;
						end
					end
					cfe_pkg::REQ_EXISTS: begin
						nxt = (hit_fp || scan_end) ? cfe_pkg::B_OUT : cfe_pkg::B_RD;
					end
					default: nxt = scan_end ? cfe_pkg::B_OUT : cfe_pkg::B_RD;
				endcase
			end
			cfe_pkg::B_KSTART: begin
				raddr = cell_addr(idx_q, victim_q, slots);
				nxt   = (kick_q == cfg.kicks) ? cfe_pkg::B_RBSTART : cfe_pkg::B_KSWAP;
			end
			cfe_pkg::B_KSWAP: begin
				mem_we = 1'b1;
				waddr  = cell_addr(idx_q, victim_q, slots);
				wdata  = carry_q;
				nxt    = cfe_pkg::B_KMUL;
			end
			cfe_pkg::B_KMUL: nxt = cfe_pkg::B_KALT;
			cfe_pkg::B_KALT: nxt = cfe_pkg::B_KRD;
			cfe_pkg::B_KRD: begin
				raddr = cell_addr(idx_q, s_q, slots);
				nxt   = cfe_pkg::B_KCHK;
			end
			cfe_pkg::B_KCHK: begin
				if (hit_empty) begin
					mem_we   = 1'b1;
					waddr    = cell_addr(idx_q, s_q, slots);
					wdata    = carry_q;
					inc_item = 1'b1;
					nxt      = cfe_pkg::B_OUT;
				end else begin
					nxt = last_slot ? cfe_pkg::B_KSTART : cfe_pkg::B_KRD;
				end
			end
			cfe_pkg::B_RBSTART: begin
				nxt = (kick_q == cfg.kicks) ? cfe_pkg::B_OUT : cfe_pkg::B_RMUL;
			end
			cfe_pkg::B_RMUL: nxt = cfe_pkg::B_RALT;
			cfe_pkg::B_RALT: nxt = cfe_pkg::B_RRD;
			cfe_pkg::B_RRD: begin
				raddr = cell_addr(idx_q, victim_q, slots);
				nxt   = cfe_pkg::B_RSWAP;
			end
			cfe_pkg::B_RSWAP: begin
				mem_we = 1'b1;
				waddr  = cell_addr(idx_q, victim_q, slots);
				wdata  = carry_q;
				nxt    = cfe_pkg::B_RBSTART;
			end
			cfe_pkg::B_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					nxt      = cfe_pkg::B_IDLE;
				end
			end
			default: nxt = cfe_pkg::B_IDLE;
		endcase
	end

	// Control state, counters and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= cfe_pkg::B_CLEAR;
			clr_q       <= '0;
			item_q      <= '0;
			del_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= nxt;
			if (st_q == cfe_pkg::B_CLEAR) clr_q <= clr_q + AW'(1);
			if (inc_item) item_q <= item_q + 13'd1;
			if (dec_item) item_q <= item_q - 13'd1;
			if (inc_del)  del_q  <= del_q + 32'd1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Request datapath.
	always_ff @(posedge clk) begin
		case (st_q)
			cfe_pkg::B_IDLE: begin
				req_q <= cfe_pkg::req_t'(q_data[10+2*BW-1 -: 2]);
				fp_q  <= q_data[2*BW +: 8];
				b0_q  <= q_data[BW +: BW];
				b1_q  <= q_data[BW-1:0];
				k_q   <= 1'b0;
				s_q   <= '0;
				cnt_q <= '0;
				okr_q <= 1'b0;
			end
			cfe_pkg::B_CHK: begin
				if (req_q == cfe_pkg::REQ_COUNT && hit_fp) cnt_q <= cnt_q + 4'd1;
				if ((req_q == cfe_pkg::REQ_INSERT && hit_empty) ||
						(req_q == cfe_pkg::REQ_EXISTS && hit_fp) ||
						(req_q == cfe_pkg::REQ_DELETE && hit_fp)) begin
					okr_q <= 1'b1;
				end else if (last_slot) begin
					s_q <= '0;
					k_q <= 1'b1;
				end else begin
					s_q <= s_q + SIW'(1);
				end
				// Set up the displacement walk in case both buckets are full.
				idx_q    <= b0_q;
				victim_q <= '0;
				carry_q  <= fp_q;
				kick_q   <= '0;
			end
			cfe_pkg::B_KSTART: begin
				if (kick_q == cfg.kicks) kick_q <= '0;
			end
			cfe_pkg::B_KSWAP, cfe_pkg::B_RSWAP: begin
				carry_q <= rdata_q;
				if (st_q == cfe_pkg::B_RSWAP) kick_q <= kick_q + 10'd1;
			end
			cfe_pkg::B_KMUL, cfe_pkg::B_RMUL: begin
				prod_q <= cfe_pkg::PROD_W'(carry_q) * cfe_pkg::PROD_W'(cfe_pkg::ALT_MUL);
			end
			cfe_pkg::B_KALT, cfe_pkg::B_RALT: begin
				idx_q <= (idx_q ^ prod_q[BW-1:0]) & mask;
				s_q   <= '0;
			end
			cfe_pkg::B_KCHK: begin
				if (hit_empty) begin
					okr_q <= 1'b1;
				end else if (last_slot) begin
					victim_q <= victim_up;
					kick_q   <= kick_q + 10'd1;
					s_q      <= '0;
				end else begin
					s_q <= s_q + SIW'(1);
				end
			end
			cfe_pkg::B_RBSTART: begin
				if (kick_q != cfg.kicks) victim_q <= victim_dn;
			end
			default: ;
		endcase
		if (out_load) begin
			ok_o_q    <= okr_q || (req_q == cfe_pkg::REQ_COUNT && cnt_q != 4'd0);
			cnt_o_q   <= cnt_q;
			items_o_q <= item_q;
			del_o_q   <= del_q;
		end
	end

endmodule

// ===== rtl/core/cuckoo_filter_engine.sv =====
// ----------------------------------------------------------------------------
// cuckoo_filter_engine
// Cuckoo filter of 8-bit fingerprints: insert, exists, delete and count.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   req_type, hash_value
//  out      out_valid / out_ready ok, match_count, items_stored, deletes_done
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// The front end forms the fingerprint, first bucket and multiplier product,
// taking no new request until its entry is pushed. The back end reads the
// table slot by slot over up to 2*slots slots, plus kick and undo steps.
// After reset a clearing pass over 2^LOG2_MAX_BUCKETS*MAX_SLOTS cells runs
// with in_ready low. A stalled output holds one result while the queue takes
// up to two more requests.
// ----------------------------------------------------------------------------
module cuckoo_filter_engine #(
	parameter int LOG2_MAX_BUCKETS = cfe_pkg::LOG2_MAX_BUCKETS_DEF,
	parameter int MAX_SLOTS        = cfe_pkg::MAX_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [63:0] hash_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [3:0]  match_count,
	output logic [12:0] items_stored,
	output logic [31:0] deletes_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam int BW = LOG2_MAX_BUCKETS;
	localparam int EW = 10 + 2 * BW;

	logic [3:0] log2_q;
	logic [2:0] slots_q;
	logic [9:0] kicks_q;

	cfe_pkg::cfg_t  cfg;
	cfe_pkg::stat_t stat;
	logic [BW-1:0]  mask;
	logic           push_valid, push_ready, pop_valid, pop_ready;
	logic [EW-1:0]  push_data, pop_data;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q  <= cfe_pkg::LOG2_RST;
			slots_q <= cfe_pkg::SLOTS_RST;
			kicks_q <= cfe_pkg::KICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cfe_pkg::CFG_LOG2:  log2_q  <= cfg_data[3:0];
				cfe_pkg::CFG_SLOTS: slots_q <= cfg_data[2:0];
				cfe_pkg::CFG_KICKS: kicks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturated geometry and bucket mask.
	always_comb begin
		cfg.log2  = (5'(log2_q) > 5'(BW)) ? 5'(BW) : 5'(log2_q);
		if (slots_q == 3'd0) cfg.slots = 4'd1;
		else if (4'(slots_q) > 4'(MAX_SLOTS)) cfg.slots = 4'(MAX_SLOTS);
		else cfg.slots = 4'(slots_q);
		cfg.kicks = kicks_q;
		for (int i = 0; i < BW; i++) begin
			mask[i] = (5'(i) < cfg.log2);
		end
	end

	cfe_front #(
		.LOG2_MAX_BUCKETS(LOG2_MAX_BUCKETS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.hash_value(hash_value),
		.mask      (mask),
		.stat      (stat),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	cfe_queue #(
		.WIDTH(EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	cfe_back #(
		.LOG2_MAX_BUCKETS(LOG2_MAX_BUCKETS),
		.MAX_SLOTS       (MAX_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.mask        (mask),
		.q_valid     (pop_valid),
		.q_ready     (pop_ready),
		.q_data      (pop_data),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.match_count (match_count),
		.items_stored(items_stored),
		.deletes_done(deletes_done)
	);

endmodule

// ===== rtl/core/cfe_checker.sv =====
// ----------------------------------------------------------------------------
// cfe_checker
// Port-level checks of the cuckoo filter engine, bound to the top level.
// ----------------------------------------------------------------------------
module cfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        ok,
	input logic [3:0]  match_count,
	input logic [12:0] items_stored,
	input logic [31:0] deletes_done
);

	// A result beat that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// Two candidate buckets hold at most eight matches.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_count <= 4'd8)
		else $error("match count out of range");

	// A nonzero count always reports a hit.
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_count != 4'd0 |-> ok)
		else $error("count reported without ok");

	// The table is still clearing right after reset, so no request is taken.
	a_clear_gate: assert property (@(posedge clk)
		$rose(arst_n) |-> !in_ready)
		else $error("request taken during clearing pass");

endmodule

bind cuckoo_filter_engine cfe_checker u_cfe_checker (.*);

// ===== verif/tb_cuckoo_filter_engine.sv =====
// ----------------------------------------------------------------------------
// tb_cuckoo_filter_engine
// Self-checking testbench for the cuckoo filter engine. A directed table walks
// the corner cases (empty table, extreme hashes, one bucket searched twice,
// insert failure with no kicks, saturating registers). Random phases under
// several geometries then mix inserts, lookups, deletes and counts. An
// in-testbench table model predicts the result beats that no directed row fixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cuckoo_filter_engine;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int TBL_CELLS = 4096;

	typedef struct {
		logic        ok;
		logic [3:0]  cnt;
		logic [12:0] items;
		logic [31:0] dels;
	} result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		cfe_pkg::req_t  req;
		logic [63:0]    hash;
		logic           typed;
		result_t        res;
		logic [1:0]     idx;
		logic [9:0]     data;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = cfe_pkg::REQ_EXISTS;
	logic [63:0] hash_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        ok;
	logic [3:0]  match_count;
	logic [12:0] items_stored;
	logic [31:0] deletes_done;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = cfe_pkg::CFG_LOG2;
	logic [9:0]  cfg_data = '0;

	cuckoo_filter_engine dut (.*);

	always #1 clk = ~clk;

	// Model state of the filter.
	logic [7:0]  fp_table [0:TBL_CELLS-1];
	logic [12:0] item_cnt;
	logic [31:0] del_cnt;
	logic [3:0]  m_log2;
	logic [2:0]  m_slots;
	logic [9:0]  m_kicks;

	result_t     pending_results [$];
	stim_row_t   dir_rows [$];
	logic [63:0] hash_pool [$];
	logic        typed_next = 1'b0;
	result_t     typed_res;
	logic        steady = 1'b0;
	int          fail_cnt = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          cfg_writes = 0;
	int          failed_inserts = 0;

	function automatic int unsigned slot_cell(logic [63:0] bkt, int unsigned s, int unsigned n);
		logic [63:0] a;
		a = bkt * n + s;
		return int'(a % TBL_CELLS);
	endfunction

	function automatic logic [63:0] alt_of(logic [7:0] fp, logic [63:0] idx, logic [63:0] msk);
		return (idx ^ (64'(fp) * 64'(cfe_pkg::ALT_MUL))) & msk;
	endfunction

	// Displacement walk with rollback on failure.
	function automatic logic kick_insert(logic [7:0] fp, logic [63:0] start,
			logic [63:0] msk, int unsigned n);
		logic [63:0] idx;
		int unsigned victim, c, d;
		logic [7:0] carry, t;
		idx = start;
		victim = 0;
		carry = fp;
		for (int i = 0; i < m_kicks; i++) begin
			c = slot_cell(idx, victim, n);
			t = fp_table[c];
			fp_table[c] = carry;
			carry = t;
			idx = alt_of(carry, idx, msk);
			for (int s = 0; s < n; s++) begin
				d = slot_cell(idx, s, n);
				if (fp_table[d] == 8'd0) begin
					fp_table[d] = carry;
					return 1'b1;
				end
			end
			victim = (victim + 1) % n;
		end
		for (int i = 0; i < m_kicks; i++) begin
			victim = (victim + n - 1) % n;
			idx = alt_of(carry, idx, msk);
			c = slot_cell(idx, victim, n);
			t = fp_table[c];
			fp_table[c] = carry;
			carry = t;
		end
		return 1'b0;
	endfunction

	// Applies one request to the model and returns its result.
	function automatic result_t filter_step(cfe_pkg::req_t rq, logic [63:0] h);
		result_t r;
		int unsigned n, l, c;
		logic [63:0] msk;
		logic [63:0] bk [2];
		logic [7:0] fp;
		n = (m_slots == 0) ? 1 : (m_slots > 4) ? 4 : m_slots;
		l = (m_log2 > 10) ? 10 : m_log2;
		msk = (64'd1 << l) - 1;
		fp = 8'(h % 64'd255 + 1);
		bk[0] = h & msk;
		bk[1] = alt_of(fp, bk[0], msk);
		r.ok = 1'b0;
		r.cnt = '0;
		case (rq)
			cfe_pkg::REQ_INSERT: begin
				for (int k = 0; k < 2 && !r.ok; k++)
					for (int s = 0; s < n && !r.ok; s++) begin
						c = slot_cell(bk[k], s, n);
						if (fp_table[c] == 8'd0) begin
							fp_table[c] = fp;
							r.ok = 1'b1;
						end
					end
				if (!r.ok) r.ok = kick_insert(fp, bk[0], msk, n);
				if (r.ok) item_cnt = item_cnt + 1'b1;
				else failed_inserts++;
			end
			cfe_pkg::REQ_EXISTS: begin
				for (int k = 0; k < 2; k++)
					for (int s = 0; s < n; s++)
						if (fp_table[slot_cell(bk[k], s, n)] == fp) r.ok = 1'b1;
			end
			cfe_pkg::REQ_DELETE: begin
				for (int k = 0; k < 2 && !r.ok; k++)
					for (int s = 0; s < n && !r.ok; s++) begin
						c = slot_cell(bk[k], s, n);
						if (fp_table[c] == fp) begin
							fp_table[c] = 8'd0;
							item_cnt = item_cnt - 1'b1;
							del_cnt = del_cnt + 1'b1;
							r.ok = 1'b1;
						end
					end
			end
			default: begin
				for (int k = 0; k < 2; k++)
					for (int s = 0; s < n; s++)
						if (fp_table[slot_cell(bk[k], s, n)] == fp) r.cnt = r.cnt + 1'b1;
				r.ok = (r.cnt != 0);
			end
		endcase
		r.items = item_cnt;
		r.dels = del_cnt;
		return r;
	endfunction

	// Input beat: predict and queue the expected result.
	always @(posedge clk) begin
		result_t r;
		if (in_valid && in_ready) begin
			r = filter_step(cfe_pkg::req_t'(req_type), hash_value);
			pending_results.push_back(typed_next ? typed_res : r);
			beats_in++;
		end
	end

	// Output beat: compare against the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (out_valid && out_ready) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				fail_cnt++;
			end else begin
				e = pending_results.pop_front();
				if (ok !== e.ok) begin
					$error("ok: expected %0d, got %0d", e.ok, ok);
					fail_cnt++;
				end
				if (match_count !== e.cnt) begin
					$error("match_count: expected %0d, got %0d", e.cnt, match_count);
					fail_cnt++;
				end
				if (items_stored !== e.items) begin
					$error("items_stored: expected %0d, got %0d", e.items, items_stored);
					fail_cnt++;
				end
				if (deletes_done !== e.dels) begin
					$error("deletes_done: expected %0d, got %0d", e.dels, deletes_done);
					fail_cnt++;
				end
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk)
		out_ready <= steady || ($urandom_range(99) >= 12);

	task automatic drain();
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic send_req(cfe_pkg::req_t rq, logic [63:0] h, logic typed, result_t res);
		if (!steady && $urandom_range(99) < 12) begin
			in_valid = 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		req_type = rq;
		hash_value = h;
		typed_next = typed;
		typed_res = res;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] data);
		in_valid = 1'b0;
		drain();
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			cfe_pkg::CFG_LOG2:  m_log2 = data[3:0];
			cfe_pkg::CFG_SLOTS: m_slots = data[2:0];
			cfe_pkg::CFG_KICKS: m_kicks = data;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic void add_item(cfe_pkg::req_t rq, logic [63:0] h, logic typed,
			logic o = 0, logic [3:0] c = 0, logic [12:0] it = 0, logic [31:0] d = 0);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.req = rq;
		row.hash = h;
		row.typed = typed;
		row.res = '{o, c, it, d};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(logic [1:0] idx, logic [9:0] data);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.req = cfe_pkg::REQ_EXISTS;
		row.hash = '0;
		row.typed = 1'b0;
		row.res = '{0, 0, 0, 0};
		row.idx = idx;
		row.data = data;
		dir_rows.push_back(row);
	endfunction

	task automatic random_phase(int unsigned n_items, logic hold_mid);
		cfe_pkg::req_t rq;
		logic [63:0] h;
		int unsigned r;
		result_t none;
		none = '{0, 0, 0, 0};
		for (int i = 0; i < n_items; i++) begin
			if (hold_mid && i == n_items / 2) begin
				in_valid = 1'b0;
				drain();
			end
			r = $urandom_range(99);
			rq = (r < 40) ? cfe_pkg::REQ_INSERT : (r < 60) ? cfe_pkg::REQ_EXISTS :
				(r < 80) ? cfe_pkg::REQ_DELETE : cfe_pkg::REQ_COUNT;
			if (hash_pool.size() != 0 && $urandom_range(99) < 55)
				h = hash_pool[$urandom_range(hash_pool.size() - 1)];
			else
				h = {$urandom, $urandom};
			if (rq == cfe_pkg::REQ_INSERT) begin
				hash_pool.push_back(h);
				if (hash_pool.size() > 64) void'(hash_pool.pop_front());
			end
			send_req(rq, h, 1'b0, none);
		end
	endtask

	initial begin
		int unsigned ph [7][4];
		result_t none;
		none = '{0, 0, 0, 0};
		for (int i = 0; i < TBL_CELLS; i++) fp_table[i] = 8'd0;
		item_cnt = '0;
		del_cnt = '0;
		m_log2 = cfe_pkg::LOG2_RST;
		m_slots = cfe_pkg::SLOTS_RST;
		m_kicks = cfe_pkg::KICKS_RST;

		// Directed rows: empty table, extremes, shared bucket, no-kick failure, saturating registers.
		add_item(cfe_pkg::REQ_EXISTS, 64'd0, 1, 0, 0, 0, 0);
		add_item(cfe_pkg::REQ_COUNT, '1, 1, 0, 0, 0, 0);
		add_item(cfe_pkg::REQ_DELETE, 64'h1234, 1, 0, 0, 0, 0);
		add_item(cfe_pkg::REQ_INSERT, 64'd0, 1, 1, 0, 1, 0);
		add_item(cfe_pkg::REQ_EXISTS, 64'd0, 1, 1, 0, 1, 0);
		add_item(cfe_pkg::REQ_COUNT, 64'd0, 1, 1, 1, 1, 0);
		add_item(cfe_pkg::REQ_INSERT, '1, 1, 1, 0, 2, 0);
		add_item(cfe_pkg::REQ_DELETE, 64'd0, 1, 1, 0, 1, 1);
		add_cfg(cfe_pkg::CFG_LOG2, 10'd0);
		add_item(cfe_pkg::REQ_INSERT, 64'd5, 1, 1, 0, 2, 1);
		add_item(cfe_pkg::REQ_COUNT, 64'd5, 1, 1, 2, 2, 1);
		add_cfg(cfe_pkg::CFG_SLOTS, 10'd1);
		add_cfg(cfe_pkg::CFG_KICKS, 10'd0);
		add_item(cfe_pkg::REQ_INSERT, 64'd7, 1, 0, 0, 2, 1);
		add_item(cfe_pkg::REQ_COUNT, 64'd5, 1, 1, 2, 2, 1);
		add_cfg(cfe_pkg::CFG_LOG2, 10'h3ff);
		add_cfg(cfe_pkg::CFG_SLOTS, 10'd7);
		add_cfg(cfe_pkg::CFG_KICKS, 10'd1023);
		add_cfg(CFG_SPARE, 10'h3ff);
		add_item(cfe_pkg::REQ_INSERT, 64'd254, 0);
		add_item(cfe_pkg::REQ_INSERT, 64'h8000_0000_0000_0000, 0);
		add_item(cfe_pkg::REQ_COUNT, 64'h5555_5555_aaaa_aaaa, 0);
		add_item(cfe_pkg::REQ_EXISTS, 64'd254, 0);
		add_item(cfe_pkg::REQ_DELETE, '1, 0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				send_req(dir_rows[i].req, dir_rows[i].hash, dir_rows[i].typed,
					dir_rows[i].res);
		end
		typed_next = 1'b0;

		// Random phases: log2 buckets, slots, kick limit, item count.
		ph = '{'{10, 2, 20, 300}, '{0, 1, 1023, 25}, '{2, 4, 0, 120},
			'{15, 7, 5, 120}, '{3, 0, 3, 120}, '{5, 1, 200, 80}, '{6, 4, 10, 150}};
		foreach (ph[p]) begin
			write_reg(cfe_pkg::CFG_LOG2, 10'(ph[p][0]));
			write_reg(cfe_pkg::CFG_SLOTS, 10'(ph[p][1]));
			write_reg(cfe_pkg::CFG_KICKS, 10'(ph[p][2]));
			steady = (p == 4);
			random_phase(ph[p][3], p == 0);
		end
		steady = 1'b0;
		in_valid = 1'b0;
		drain();
		repeat (50) @(negedge clk);

		$display("Covered %0d requests and %0d results over %0d register writes.",
			beats_in, beats_out, cfg_writes);
		$display("Inserts rejected after a failed displacement walk: %0d.", failed_inserts);
		if (fail_cnt == 0 && pending_results.size() == 0)
			$display("cuckoo_filter_engine test passed");
		else
			$display("cuckoo_filter_engine test failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#20_000_000;
		$display("cuckoo_filter_engine test failed");
		$finish;
	end

endmodule

// ===== cuckoo_filter_engine.f =====
rtl/core/cfe_pkg.sv
rtl/core/cfe_front.sv
rtl/core/cfe_queue.sv
rtl/core/cfe_back.sv
rtl/core/cuckoo_filter_engine.sv
rtl/core/cfe_checker.sv
verif/tb_cuckoo_filter_engine.sv
